// ===== src/isgf_pkg.sv =====
package isgf_pkg;

    localparam int SAMPLE_WIDTH     = 24;
    localparam int MAX_SWEEP_POINTS = 4096;
    localparam int COUNT_W          = $clog2(MAX_SWEEP_POINTS + 1);

    // record queue sizing: up to two pushes and one pop per cycle
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [COUNT_W-1:0]             t_count;

    typedef struct packed {
        t_sample value;
        t_count  count;
        logic    is_fill;
        logic    unresolved;
        logic    sweep_end;
        logic    last_of_item;
    } t_rec;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

// ===== src/invalid_sample_gap_filler_core.sv =====
// Invalid sample gap filler.
// Input channel: i_in_valid / o_in_stall with one sweep point per beat
// (i_sample_value, i_not_finite, i_sweep_end). Output channel:
// o_out_valid / i_out_stall with one record per beat. A good point gives a
// record with repeat count 1; a run of invalid points gives one fill record
// whose count is the run length, placed ahead of the good point that ends it
// or emitted alone when the sweep ends inside the run.
// Configuration: i_cfg_we writes i_cfg_data into the negative-is-invalid flag;
// write it only while no sweep point is in flight.
// An accepted point passes the input register, then the record queue.
// Throughput: one point per cycle while the queue has room. The queue holds
// four records and takes a point only while two slots are free, so stalls
// on the input side come from a stalled receiver or from fill beats that
// double the record rate.
// Reset (synchronous, active low) empties the queue, clears the gap state,
// starts a new sweep and sets the negative-is-invalid flag. While the
// receiver stalls, the head record holds and the queue fills, then the
// input channel stalls.
module invalid_sample_gap_filler_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [isgf_pkg::SAMPLE_WIDTH-1:0] i_sample_value,
    input  logic                       i_not_finite,
    input  logic                       i_sweep_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [isgf_pkg::SAMPLE_WIDTH-1:0] o_out_value,
    output logic [isgf_pkg::COUNT_W-1:0] o_repeat_count,
    output logic                       o_is_fill,
    output logic                       o_unresolved,
    output logic                       o_out_sweep_end,
    output logic                       o_last_of_item
);
    import isgf_pkg::*;

    logic  r_neg_inv;
    logic  room;
    t_push push;
    t_rec  rec0;
    t_rec  rec1;
    t_rec  head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_inv <= 1'b1;
        end else if (i_cfg_we) begin
            r_neg_inv <= i_cfg_data;
        end
    end

    isgf_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_neg_inv      (r_neg_inv),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_not_finite   (i_not_finite),
        .i_sweep_end    (i_sweep_end),
        .i_room         (room),
        .o_push         (push),
        .o_rec0         (rec0),
        .o_rec1         (rec1)
    );

    isgf_rec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec0  (rec0),
        .i_rec1  (rec1),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_rec   (head)
    );

    assign o_out_value     = head.value;
    assign o_repeat_count  = head.count;
    assign o_is_fill       = head.is_fill;
    assign o_unresolved    = head.unresolved;
    assign o_out_sweep_end = head.sweep_end;
    assign o_last_of_item  = head.last_of_item;

endmodule

// ===== src/isgf_track.sv =====
module isgf_track (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_neg_inv,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  isgf_pkg::t_sample     i_sample_value,
    input  logic                  i_not_finite,
    input  logic                  i_sweep_end,
    input  logic                  i_room,
    output isgf_pkg::t_push       o_push,
    output isgf_pkg::t_rec        o_rec0,
    output isgf_pkg::t_rec        o_rec1
);
    import isgf_pkg::*;

    logic    r_in_vld;
    t_sample r_in_value;
    logic    r_in_nf;
    logic    r_in_end;

    t_sample r_last_good, n_last_good;
    t_sample r_first_raw, n_first_raw;
    t_count  r_gap_len, n_gap_len;
    logic    r_in_gap, n_in_gap;
    logic    r_leading, n_leading;
    logic    r_at_start, n_at_start;

    logic                    advance;
    logic                    invalid;
    logic signed [SAMPLE_WIDTH:0] sum;
    t_sample                 half;
    t_count                  gap_inc;

    assign advance    = r_in_vld && i_room;
    assign o_in_stall = r_in_vld && !i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_value <= i_sample_value;
            r_in_nf    <= i_not_finite;
            r_in_end   <= i_sweep_end;
        end
    end

    assign invalid = r_in_nf || (i_neg_inv && r_in_value[SAMPLE_WIDTH-1]);
    assign sum     = {r_last_good[SAMPLE_WIDTH-1], r_last_good}
                   + {r_in_value[SAMPLE_WIDTH-1], r_in_value};
    // arithmetic shift right by one of the sum
    assign half    = sum[SAMPLE_WIDTH:1];
    assign gap_inc = (r_gap_len < COUNT_W'(MAX_SWEEP_POINTS)) ? r_gap_len + 1'b1 : r_gap_len;

    always_comb begin
        n_last_good = r_last_good;
        n_first_raw = r_at_start ? r_in_value : r_first_raw;
        n_gap_len   = r_gap_len;
        n_in_gap    = r_in_gap;
        n_leading   = r_leading;
        n_at_start  = r_at_start;
        o_push      = '0;
        o_rec0      = '0;
        o_rec1      = '0;

        if (invalid) begin
            if (r_at_start) begin
                n_in_gap  = 1'b1;
                n_leading = 1'b1;
                n_gap_len = COUNT_W'(1);
            end else if (!r_in_gap) begin
                n_in_gap  = 1'b1;
                n_leading = 1'b0;
                n_gap_len = COUNT_W'(1);
            end else begin
                n_gap_len = gap_inc;
            end
            n_at_start = 1'b0;
            if (r_in_end) begin
                o_push.first        = 1'b1;
                o_rec0.value        = n_leading ? n_first_raw : r_last_good;
                o_rec0.count        = n_gap_len;
                o_rec0.is_fill      = 1'b1;
                o_rec0.unresolved   = n_leading;
                o_rec0.sweep_end    = 1'b1;
                o_rec0.last_of_item = 1'b1;
                n_in_gap   = 1'b0;
                n_leading  = 1'b0;
                n_gap_len  = '0;
                n_at_start = 1'b1;
            end
        end else begin
            if (r_in_gap) begin
                // close the run: fill beat first, then the good sample
                o_push.first        = 1'b1;
                o_push.second       = 1'b1;
                o_rec0.value        = r_leading ? r_in_value : half;
                o_rec0.count        = r_gap_len;
                o_rec0.is_fill      = 1'b1;
                o_rec1.value        = r_in_value;
                o_rec1.count        = COUNT_W'(1);
                o_rec1.sweep_end    = r_in_end;
                o_rec1.last_of_item = 1'b1;
            end else begin
                o_push.first        = 1'b1;
                o_rec0.value        = r_in_value;
                o_rec0.count        = COUNT_W'(1);
                o_rec0.sweep_end    = r_in_end;
                o_rec0.last_of_item = 1'b1;
            end
            n_last_good = r_in_value;
            n_in_gap    = 1'b0;
            n_leading   = 1'b0;
            n_gap_len   = '0;
            n_at_start  = r_in_end;
        end

        if (!advance) begin
            o_push = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_good <= '0;
            r_first_raw <= '0;
            r_gap_len   <= '0;
            r_in_gap    <= 1'b0;
            r_leading   <= 1'b0;
            r_at_start  <= 1'b1;
        end else if (advance) begin
            r_last_good <= n_last_good;
            r_first_raw <= n_first_raw;
            r_gap_len   <= n_gap_len;
            r_in_gap    <= n_in_gap;
            r_leading   <= n_leading;
            r_at_start  <= n_at_start;
        end
    end

endmodule

// ===== src/isgf_rec_fifo.sv =====
module isgf_rec_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isgf_pkg::t_push   i_push,
    input  isgf_pkg::t_rec    i_rec0,
    input  isgf_pkg::t_rec    i_rec1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output isgf_pkg::t_rec    o_rec
);
    import isgf_pkg::*;

    t_rec             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_ptr1;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    // keep space for a two-beat push regardless of the pop
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count - CNT_W'(pop);
        if (i_push.first && i_push.second) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(2);
            n_count  = n_count + CNT_W'(2);
        end else if (i_push.first) begin
            n_wr_ptr = wr_ptr1;
            n_count  = n_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
        if (i_push.first) begin
            r_mem[r_wr_ptr] <= i_rec0;
        end
        if (i_push.second) begin
            r_mem[wr_ptr1] <= i_rec1;
        end
    end

endmodule
